// ===== src/assert_macros.svh =====
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check, reset-qualified
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// next-cycle implication check
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

// ===== src/sha_pkg.sv =====
// Package: SHA-256 constants, types and round functions
`default_nettype none
package sha_pkg;
   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_ROUND, ST_ADD, ST_PAD, ST_EMIT
   } state_type;

   typedef logic [255:0] hash_type;

   localparam hash_type INIT_HASH = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_START = 6'd56;

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k [64];
      k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[t];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction
endpackage
`default_nettype wire

// ===== src/sha_stream_if.sv =====
// Valid/ready stream interfaces for byte requests and digest-word responses
`default_nettype none
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       is_last;
   modport source (output valid, data_byte, byte_valid, is_last, input ready);
   modport sink (input valid, data_byte, byte_valid, is_last, output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== src/sha256_stream_hasher_top.sv =====
// A byte that completes a block stalls input while the block is loaded and compressed.
// A last item takes one or two compressions, then eight digest words, one a cycle while rsp.ready is high.
// Throughput: one byte per cycle while filling; the single round unit sets the stall.
// Reset: synchronous; restores the initial hash, empties the buffer and length.
// The buffer memory needs no clearing pass; padding rewrites every unused byte.
`default_nettype none
`include "assert_macros.svh"
module sha256_stream_hasher_top (
   input wire logic clock,
   input wire logic reset,
   sha_req_if.sink   req,
   sha_rsp_if.source rsp
);
   sha_pkg::state_type state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] total_ff, total_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        last_ff, last_in;    // finishing a message
   logic        lenblk_ff, lenblk_in; // current pad block carries the length
   logic [2:0]  oidx_ff, oidx_in;
   logic        wr_en;
   logic [3:0]  wr_addr, wr_be, rd_addr;
   logic [31:0] wr_data, rd_data;
   logic        start, load_w, round_en, finish, init;
   sha_pkg::hash_type hash;
   logic [63:0] bit_len;

   sha_buf_ram u_ram (.clock, .wr_en, .wr_addr, .wr_be, .wr_data, .rd_addr, .rd_data);
   sha_core u_core (.clock, .start, .load_w, .w_in(rd_data), .round_en,
      .round_idx(cnt_ff[5:0] - 6'd16), .finish, .init, .hash);

   assign bit_len = {total_ff, 3'b000};
   assign rsp.digest_word = hash[255 - 32*oidx_ff -: 32];
   assign rsp.word_index = oidx_ff;
   assign rsp.last_word = (oidx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha_pkg::ST_IDLE;
         fill_ff <= '0; total_ff <= '0; cnt_ff <= '0;
         last_ff <= 1'b0; lenblk_ff <= 1'b0; oidx_ff <= '0;
      end else begin
         state_ff <= state_in; fill_ff <= fill_in; total_ff <= total_in;
         cnt_ff <= cnt_in; last_ff <= last_in; lenblk_ff <= lenblk_in;
         oidx_ff <= oidx_in;
      end
   end

   always_comb begin
      state_in = state_ff; fill_in = fill_ff; total_in = total_ff; cnt_in = cnt_ff;
      last_in = last_ff; lenblk_in = lenblk_ff; oidx_in = oidx_ff;
      req.ready = 1'b0; rsp.valid = 1'b0;
      wr_en = 1'b0; wr_addr = fill_ff[5:2]; wr_be = 4'b0; wr_data = '0;
      rd_addr = cnt_ff[3:0];
      start = 1'b0; load_w = 1'b0; round_en = 1'b0; finish = 1'b0; init = reset;
      case (state_ff)
         sha_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               wr_data = {4{req.byte_valid ? req.data_byte : sha_pkg::PAD_MARK}};
               if (req.byte_valid || req.is_last) begin
                  wr_en = 1'b1;
                  wr_be = 4'b1000 >> fill_ff[1:0];
               end
               if (req.byte_valid) begin
                  fill_in = fill_ff + 6'd1;
                  total_in = total_ff + 61'd1;
               end
               last_in = req.is_last;
               if (req.byte_valid && fill_ff == 6'd63) begin
                  lenblk_in = 1'b0;
                  cnt_in = '0; state_in = sha_pkg::ST_LOAD;
               end else if (req.is_last) begin
                  cnt_in = {1'b0, req.byte_valid ? fill_ff + 6'd1 : fill_ff};
                  state_in = sha_pkg::ST_PAD;
               end
            end
         end
         sha_pkg::ST_PAD: begin
            // place the pad marker, zero the rest, then the length
            wr_en = 1'b1;
            wr_addr = cnt_ff[5:2];
            if (cnt_ff == 7'd64) begin
               wr_en = 1'b0;
               cnt_in = '0; state_in = sha_pkg::ST_LOAD;
            end else if (lenblk_ff && cnt_ff[5:0] >= sha_pkg::LEN_START) begin
               wr_be = 4'b1111;
               wr_data = cnt_ff[2] ? bit_len[31:0] : bit_len[63:32];
               cnt_in = cnt_ff + 7'd4;
            end else begin
               // fill out the word from the current byte lane down
               wr_be = 4'b1111 >> cnt_ff[1:0];
               // first write of the message's pad block carries the marker
               if (!lenblk_ff && cnt_ff == {1'b0, fill_ff})
                  wr_data = {sha_pkg::PAD_MARK, 24'h0} >> {cnt_ff[1:0], 3'b000};
               cnt_in = {cnt_ff[6:2] + 5'd1, 2'b00};
               if (!lenblk_ff && cnt_in[5:0] >= sha_pkg::LEN_START && fill_ff <= 6'd55)
                  lenblk_in = 1'b1;
            end
         end
         sha_pkg::ST_LOAD: begin
            // read one word per cycle; each word passes through the registered read port before it enters the window
            rd_addr = cnt_ff[3:0];
            if (cnt_ff != 7'd0) load_w = 1'b1;
            if (cnt_ff == 7'd16) begin
               start = 1'b1; cnt_in = 7'd16; state_in = sha_pkg::ST_ROUND;
            end else cnt_in = cnt_ff + 7'd1;
         end
         sha_pkg::ST_ROUND: begin
            round_en = 1'b1;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd79) state_in = sha_pkg::ST_ADD;
         end
         sha_pkg::ST_ADD: begin
            finish = 1'b1;
            fill_in = '0;
            if (!last_ff) state_in = sha_pkg::ST_IDLE;
            else if (lenblk_ff) begin
               oidx_in = '0; state_in = sha_pkg::ST_EMIT;
            end else begin
               // next block is the pad block: zeros and the length, with the marker only if the block filled exactly
               cnt_in = {1'b0, fill_ff};
               if (fill_ff == 6'd0) begin
                  // block filled exactly: marker starts a fresh block
                  wr_en = 1'b1; wr_addr = '0; wr_be = 4'b1000;
                  wr_data = {sha_pkg::PAD_MARK, 24'h0};
                  cnt_in = 7'd1;
               end else cnt_in = 7'd0;
               lenblk_in = 1'b1;
               state_in = sha_pkg::ST_PAD;
            end
         end
         sha_pkg::ST_EMIT: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  init = 1'b1;
                  fill_in = '0; total_in = '0; last_in = 1'b0; lenblk_in = 1'b0;
                  state_in = sha_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sha_pkg::ST_IDLE;
      endcase
   end

   `ASSERT_IMPL(a_ready_idle, clock, reset, req.ready, state_ff == sha_pkg::ST_IDLE,
      "input taken outside idle")
   `ASSERT_IMPL(a_emit_len, clock, reset, rsp.valid, lenblk_ff && last_ff,
      "digest without length block")
   `ASSERT_NEXT(a_wrap, clock, reset, rsp.valid && rsp.ready && rsp.last_word,
      state_ff == sha_pkg::ST_IDLE && total_ff == 61'd0, "no return to idle")
endmodule
`default_nettype wire

// ===== src/sha_buf_ram.sv =====
// Block buffer memory: 16 x 32-bit words with byte write, registered read
`default_nettype none
module sha_buf_ram (
   input  wire logic        clock,
   input  wire logic        wr_en,
   input  wire logic [3:0]  wr_addr,
   input  wire logic [3:0]  wr_be,
   input  wire logic [31:0] wr_data,
   input  wire logic [3:0]  rd_addr,
   output logic      [31:0] rd_data
);
   logic [31:0] mem [16];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int b = 0; b < 4; b++) begin
            if (wr_be[b]) mem[wr_addr][b*8 +: 8] <= wr_data[b*8 +: 8];
         end
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== src/sha_core.sv =====
// SHA-256 compression datapath: schedule window and one round per cycle while round_en is high
`default_nettype none
module sha_core (
   input  wire logic                clock,
   input  wire logic                start,
   input  wire logic                load_w,
   input  wire logic [31:0]         w_in,
   input  wire logic                round_en,
   input  wire logic [5:0]          round_idx,
   input  wire logic                finish,
   input  wire logic                init,
   output sha_pkg::hash_type        hash
);
   logic [31:0] w_ff [16];
   logic [31:0] wa_ff [8];
   sha_pkg::hash_type hash_ff;
   logic [31:0] wt, s0, s1, t1, t2, big0, big1, ch, maj, wnew;

   assign hash = hash_ff;

   always_comb begin
      s0 = sha_pkg::rotr(w_ff[1], 7) ^ sha_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = sha_pkg::rotr(w_ff[14], 17) ^ sha_pkg::rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnew = w_ff[0] + s0 + w_ff[9] + s1;
      wt = (round_idx < 6'd16) ? w_ff[0] : wnew;
      big1 = sha_pkg::rotr(wa_ff[4], 6) ^ sha_pkg::rotr(wa_ff[4], 11)
           ^ sha_pkg::rotr(wa_ff[4], 25);
      ch = (wa_ff[4] & wa_ff[5]) ^ (~wa_ff[4] & wa_ff[6]);
      t1 = wa_ff[7] + big1 + ch + sha_pkg::round_k(round_idx) + wt;
      big0 = sha_pkg::rotr(wa_ff[0], 2) ^ sha_pkg::rotr(wa_ff[0], 13)
           ^ sha_pkg::rotr(wa_ff[0], 22);
      maj = (wa_ff[0] & wa_ff[1]) ^ (wa_ff[0] & wa_ff[2]) ^ (wa_ff[1] & wa_ff[2]);
      t2 = big0 + maj;
   end

   always_ff @(posedge clock) begin
      if (init) hash_ff <= sha_pkg::INIT_HASH;
      else if (finish) begin
         for (int i = 0; i < 8; i++)
            hash_ff[255-32*i -: 32] <= hash_ff[255-32*i -: 32] + wa_ff[i];
      end
      if (start) begin
         for (int i = 0; i < 8; i++) wa_ff[i] <= hash_ff[255-32*i -: 32];
      end else if (round_en) begin
         wa_ff[0] <= t1 + t2;
         for (int i = 1; i < 8; i++) wa_ff[i] <= (i == 4) ? wa_ff[3] + t1 : wa_ff[i-1];
      end
      // shift the 16-word schedule window; loads enter at the top
      if (load_w || round_en) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= load_w ? w_in : wt;
      end
   end
endmodule
`default_nettype wire
